FILE: sv/stlb_pkg.sv
package stlb_pkg;

   // field widths fixed by the item format
   localparam int VPN_W      = 20;
   localparam int PPN_W      = 20;
   localparam int SETBITS_W  = 3;
   localparam int WAYSUSED_W = 4;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED = 2'd1;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FILL   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic eval;
      logic commit;
   } cmd_type;

endpackage

FILE: sv/stlb_ctrl.sv
module stlb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stlb_pkg::cmd_type  cmd
);

   stlb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stlb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         stlb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stlb_pkg::ST_READ;
            end
         end
         stlb_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = stlb_pkg::ST_EVAL;
         end
         stlb_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = stlb_pkg::ST_COMMIT;
         end
         stlb_pkg::ST_COMMIT: begin
            // wait until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = stlb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stlb_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != stlb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == stlb_pkg::ST_READ))
      else $error("accepted beat did not start a read");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule

FILE: sv/stlb_dpath.sv
module stlb_dpath #(
   parameter int MAX_SETS = 16,
   parameter int MAX_WAYS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stlb_pkg::cmd_type                   cmd,
   input  logic                                req_op,
   input  logic [stlb_pkg::VPN_W-1:0]          req_vpn,
   input  logic                                req_store,
   input  logic [stlb_pkg::PPN_W-1:0]          req_fill_ppn,
   input  logic                                req_fill_dirty,
   output logic                                rsp_hit,
   output logic [stlb_pkg::PPN_W-1:0]          rsp_ppn,
   output logic                                rsp_dirty_update_needed,
   input  logic                                csr_we,
   input  logic [stlb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stlb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // largest s with 2^s <= MAX_SETS
   localparam int SMAX      = $clog2(MAX_SETS + 1) - 1;
   localparam int SET_IW    = (SMAX > 0) ? SMAX : 1;
   localparam int SET_DEPTH = 1 << SMAX;
   localparam int WAY_IW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_W    = WAY_IW;
   localparam int WAY_CW    = $clog2(MAX_WAYS + 1);

   typedef struct packed {
      logic [stlb_pkg::VPN_W-1:0] tag;
      logic [stlb_pkg::PPN_W-1:0] ppn;
      logic                       dirty;
      logic [RANK_W-1:0]          rank;
   } way_type;

   typedef way_type [MAX_WAYS-1:0] row_type;

   // config registers
   logic [stlb_pkg::SETBITS_W-1:0]  set_bits_ff;
   logic [stlb_pkg::WAYSUSED_W-1:0] ways_used_ff;

   // row memory, one row per set; valid bits in flops
   row_type             mem [SET_DEPTH];
   logic [MAX_WAYS-1:0] valid_ff [SET_DEPTH];

   // request registers
   logic                       op_ff, wr_ff, fdirty_ff;
   logic [stlb_pkg::PPN_W-1:0] fppn_ff;
   logic [stlb_pkg::VPN_W-1:0] tag_ff;
   logic [SET_IW-1:0]          set_ff;
   logic [WAY_CW-1:0]          ways_ff;

   // read stage
   row_type             row_ff;
   logic [MAX_WAYS-1:0] vrow_ff;

   // eval stage
   logic [WAY_IW-1:0] sel_ff, sel_in;
   logic [WAY_CW-1:0] old_ff, old_in;
   logic              found_ff, found_in;

   // result register
   logic                       hit_ff, dru_ff;
   logic [stlb_pkg::PPN_W-1:0] ppn_ff;

   logic [stlb_pkg::SETBITS_W-1:0] sb_eff;
   logic [SET_IW-1:0]              set_mask;
   logic [WAY_CW-1:0]              ways_eff;
   row_type                        row_new;
   logic                           hit_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff  <= '0;
         ways_used_ff <= stlb_pkg::WAYSUSED_W'(1);
      end else if (csr_we) begin
         if (csr_index == stlb_pkg::CSR_SET_BITS) begin
            set_bits_ff <= csr_wdata[stlb_pkg::SETBITS_W-1:0];
         end else if (csr_index == stlb_pkg::CSR_WAYS_USED) begin
            ways_used_ff <= csr_wdata[stlb_pkg::WAYSUSED_W-1:0];
         end
      end
   end

   // effective set bits and way count
   always_comb begin
      sb_eff = (32'(set_bits_ff) > SMAX) ? stlb_pkg::SETBITS_W'(SMAX) : set_bits_ff;
      set_mask = SET_IW'((32'd1 << sb_eff) - 32'd1);
      if (ways_used_ff == '0) begin
         ways_eff = WAY_CW'(1);
      end else if (32'(ways_used_ff) > MAX_WAYS) begin
         ways_eff = WAY_CW'(MAX_WAYS);
      end else begin
         ways_eff = WAY_CW'(ways_used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_op;
         wr_ff     <= req_store;
         fppn_ff   <= req_fill_ppn;
         fdirty_ff <= req_fill_dirty;
         set_ff    <= req_vpn[SET_IW-1:0] & set_mask;
         tag_ff    <= req_vpn >> sb_eff;
         ways_ff   <= ways_eff;
      end
   end

   // memory read, registered
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         row_ff  <= mem[set_ff];
         vrow_ff <= valid_ff[set_ff];
      end
   end

   // tag compare, free way and victim search
   always_comb begin
      logic              got_match, got_free;
      logic [WAY_IW-1:0] match_w, free_w, vic_w;
      got_match = 1'b0;
      got_free  = 1'b0;
      match_w   = '0;
      free_w    = '0;
      vic_w     = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < 32'(ways_ff)) begin
            if (!got_match && vrow_ff[w] && (row_ff[w].tag == tag_ff)) begin
               got_match = 1'b1;
               match_w   = WAY_IW'(w);
            end
            if (!got_free && !vrow_ff[w]) begin
               got_free = 1'b1;
               free_w   = WAY_IW'(w);
            end
            if (row_ff[w].rank > row_ff[vic_w].rank) begin
               vic_w = WAY_IW'(w);
            end
         end
      end
      found_in = got_match;
      if (got_match) begin
         sel_in = match_w;
         old_in = WAY_CW'(row_ff[match_w].rank);
      end else if (got_free) begin
         sel_in = free_w;
         old_in = ways_ff;
      end else begin
         sel_in = vic_w;
         old_in = WAY_CW'(row_ff[vic_w].rank);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         sel_ff   <= sel_in;
         old_ff   <= old_in;
         found_ff <= found_in;
      end
   end

   // new row: age the younger ways, selected way becomes most recent; a fill writes its entry, a store hit sets dirty
   always_comb begin
      row_new = row_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if ((w < 32'(ways_ff)) && vrow_ff[w] && (w != 32'(sel_ff))) begin
            if ((WAY_CW'(row_ff[w].rank) < old_ff) &&
                (WAY_CW'(row_ff[w].rank) + WAY_CW'(1) < ways_ff)) begin
               row_new[w].rank = row_ff[w].rank + RANK_W'(1);
            end
         end
      end
      row_new[sel_ff].rank = '0;
      if (op_ff == stlb_pkg::OP_FILL) begin
         row_new[sel_ff].tag   = tag_ff;
         row_new[sel_ff].ppn   = fppn_ff;
         row_new[sel_ff].dirty = fdirty_ff;
      end else if (found_ff && wr_ff) begin
         row_new[sel_ff].dirty = 1'b1;
      end
   end

   assign hit_now = (op_ff == stlb_pkg::OP_LOOKUP) && found_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit && ((op_ff == stlb_pkg::OP_FILL) || found_ff)) begin
         mem[set_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SET_DEPTH; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (cmd.commit && (op_ff == stlb_pkg::OP_FILL)) begin
         valid_ff[set_ff][sel_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff <= hit_now;
         ppn_ff <= hit_now ? row_ff[sel_ff].ppn : '0;
         dru_ff <= hit_now && wr_ff && !row_ff[sel_ff].dirty;
      end
   end

   assign rsp_hit                 = hit_ff;
   assign rsp_ppn                 = ppn_ff;
   assign rsp_dirty_update_needed = dru_ff;

   a_sel_in_use: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && ((op_ff == stlb_pkg::OP_FILL) || found_ff))
         |-> (WAY_CW'(sel_ff) < ways_ff))
      else $error("selected way outside the ways in use");

   a_fill_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (op_ff == stlb_pkg::OP_FILL))
         |=> valid_ff[$past(set_ff)][$past(sel_ff)])
      else $error("fill did not mark its way valid");

endmodule

FILE: sv/set_assoc_tlb_lru.sv
// set-associative tlb with true lru replacement
//
// request channel (req_*): one beat per lookup or fill; op 0 looks up vpn,
// op 1 inserts vpn -> fill_ppn with fill_dirty. a beat is taken when
// req_valid is high and req_stall is low.
// response channel (rsp_*): exactly one beat per request: hit, ppn and
// dirty_update_needed; a fill always answers with all zeros.
// config channel (csr_*): index 0 set_bits, index 1 ways_used; always ready;
// the user writes it only while no request is in flight; the block does not enforce it.
// timing: a request walks idle -> read -> eval -> commit; the result is
// registered at commit and shows on rsp_valid, and the next request is
// taken only back in idle, so a new request is not taken before the last
// one has committed (read, compare, write back).
// a stalled response holds commit until the output register frees up;
// meanwhile req_stall stays high.
// reset: all entries invalid, set_bits 0, ways_used 1, no result pending.
module set_assoc_tlb_lru #(
   parameter int MAX_SETS = 16,
   parameter int MAX_WAYS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beats
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [stlb_pkg::VPN_W-1:0]      req_vpn,
   input  logic                            req_store,
   input  logic [stlb_pkg::PPN_W-1:0]      req_fill_ppn,
   input  logic                            req_fill_dirty,
   // response beats
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [stlb_pkg::PPN_W-1:0]      rsp_ppn,
   output logic                            rsp_dirty_update_needed,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stlb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stlb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   stlb_pkg::cmd_type cmd;

   // config writes are always accepted and registered directly
   assign csr_ready = 1'b1;

   // sequencer: one request at a time
   stlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // set memory, compare, lru update and result register
   stlb_dpath #(
      .MAX_SETS (MAX_SETS),
      .MAX_WAYS (MAX_WAYS)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .req_op                  (req_op),
      .req_vpn                 (req_vpn),
      .req_store               (req_store),
      .req_fill_ppn            (req_fill_ppn),
      .req_fill_dirty          (req_fill_dirty),
      .rsp_hit                 (rsp_hit),
      .rsp_ppn                 (rsp_ppn),
      .rsp_dirty_update_needed (rsp_dirty_update_needed),
      .csr_we                  (csr_valid && csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

endmodule

FILE: sim/tlb_lru_checker.sv
module tlb_lru_checker #(
   parameter int MAX_SETS = 16,
   parameter int MAX_WAYS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_op,
   input  logic [stlb_pkg::VPN_W-1:0]      req_vpn,
   input  logic                            req_store,
   input  logic [stlb_pkg::PPN_W-1:0]      req_fill_ppn,
   input  logic                            req_fill_dirty,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_hit,
   input  logic [stlb_pkg::PPN_W-1:0]      rsp_ppn,
   input  logic                            rsp_dirty_update_needed,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [stlb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stlb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              pending,
   output int                              answers_checked,
   output int                              hits_checked
);

   localparam int NUM_ENTRIES = MAX_SETS * MAX_WAYS;

   typedef struct packed {
      logic                       op;
      logic [stlb_pkg::VPN_W-1:0] vpn;
      logic                       hit;
      logic [stlb_pkg::PPN_W-1:0] ppn;
      logic                       dirty_update;
   } answer_type;

   answer_type answers_due[$];

   // shadow copy of the translation array, entry index is set*MAX_WAYS+way
   logic [stlb_pkg::VPN_W-1:0] tag_mem   [NUM_ENTRIES];
   logic [stlb_pkg::PPN_W-1:0] frame_mem [NUM_ENTRIES];
   bit                         valid_mem [NUM_ENTRIES];
   bit                         dirty_mem [NUM_ENTRIES];
   int                         age_mem   [NUM_ENTRIES];

   logic [stlb_pkg::SETBITS_W-1:0]  set_bits_cfg;
   logic [stlb_pkg::WAYSUSED_W-1:0] ways_used_cfg;

   // make one way most recent; younger valid ways age by one, capped at ways-1
   task automatic make_recent(input int base, input int ways, input int way, input int old_age);
      int i;
      for (int w = 0; w < ways; w++) begin
         i = base + w;
         if (w != way && valid_mem[i] && age_mem[i] < old_age && age_mem[i] + 1 < ways)
            age_mem[i] = age_mem[i] + 1;
      end
      age_mem[base + way] = 0;
   endtask

   task automatic translate_and_update(
      input  logic                       op,
      input  logic [stlb_pkg::VPN_W-1:0] vpn,
      input  logic                       store,
      input  logic [stlb_pkg::PPN_W-1:0] fill_ppn,
      input  logic                       fill_dirty,
      output answer_type                 answer
   );
      int sb, ways, base, match_way, victim, old_age, free_way;
      logic [stlb_pkg::VPN_W-1:0] tag;
      sb = int'(set_bits_cfg);
      while (sb > 0 && (1 << sb) > MAX_SETS)
         sb--;
      ways = (ways_used_cfg == '0) ? 1 : int'(ways_used_cfg);
      if (ways > MAX_WAYS)
         ways = MAX_WAYS;
      base = (int'(vpn) & ((1 << sb) - 1)) * MAX_WAYS;
      tag = vpn >> sb;
      match_way = -1;
      for (int w = 0; w < ways; w++)
         if (match_way < 0 && valid_mem[base + w] && tag_mem[base + w] == tag)
            match_way = w;

      answer = '0;
      answer.op = op;
      answer.vpn = vpn;
      if (op == stlb_pkg::OP_LOOKUP) begin
         if (match_way >= 0) begin
            make_recent(base, ways, match_way, age_mem[base + match_way]);
            answer.hit = 1'b1;
            answer.ppn = frame_mem[base + match_way];
            if (store && !dirty_mem[base + match_way]) begin
               dirty_mem[base + match_way] = 1'b1;
               answer.dirty_update = 1'b1;
            end
         end
      end else begin
         if (match_way >= 0) begin
            victim = match_way;
            old_age = age_mem[base + victim];
         end else begin
            free_way = -1;
            for (int w = 0; w < ways; w++)
               if (free_way < 0 && !valid_mem[base + w])
                  free_way = w;
            if (free_way >= 0) begin
               victim = free_way;
               old_age = ways;
            end else begin
               victim = 0;
               for (int w = 0; w < ways; w++)
                  if (age_mem[base + w] > age_mem[base + victim])
                     victim = w;
               old_age = age_mem[base + victim];
            end
         end
         tag_mem[base + victim] = tag;
         frame_mem[base + victim] = fill_ppn;
         dirty_mem[base + victim] = fill_dirty;
         valid_mem[base + victim] = 1'b1;
         make_recent(base, ways, victim, old_age);
      end
   endtask

   always @(posedge clock) begin : monitor
      answer_type want;
      if (reset) begin
         answers_due.delete();
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            valid_mem[i] = 1'b0;
            dirty_mem[i] = 1'b0;
            age_mem[i] = 0;
         end
         set_bits_cfg = '0;
         ways_used_cfg = stlb_pkg::WAYSUSED_W'(1);
         mismatches = 0;
         answers_checked = 0;
         hits_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response beat: hit %0b ppn %05h dirty_update %0b",
                           rsp_hit, rsp_ppn, rsp_dirty_update_needed);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               answers_checked++;
               if (want.hit)
                  hits_checked++;
               if (want.hit !== rsp_hit || want.ppn !== rsp_ppn ||
                   want.dirty_update !== rsp_dirty_update_needed) begin
                  if (mismatches < 10) begin
                     $display("mismatch op %0b vpn %05h: expected hit %0b ppn %05h du %0b",
                              want.op, want.vpn, want.hit, want.ppn, want.dirty_update);
                     $display("   got hit %0b ppn %05h du %0b",
                              rsp_hit, rsp_ppn, rsp_dirty_update_needed);
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            translate_and_update(req_op, req_vpn, req_store, req_fill_ppn,
                                 req_fill_dirty, want);
            answers_due.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               stlb_pkg::CSR_SET_BITS:  set_bits_cfg = csr_wdata[stlb_pkg::SETBITS_W-1:0];
               stlb_pkg::CSR_WAYS_USED: ways_used_cfg = csr_wdata[stlb_pkg::WAYSUSED_W-1:0];
               default: ;
            endcase
         end
      end
      pending = answers_due.size();
   end

endmodule

FILE: sim/tb.sv
module tb;

   // register indexes the block does not decode; writes there must be ignored
   localparam logic [stlb_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [stlb_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam int NUM_SETTINGS = 10;
   localparam int ITEMS_PER_SETTING = 105;
   localparam int POOL_SIZE = 32;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_op;
   logic [stlb_pkg::VPN_W-1:0]      req_vpn;
   logic                            req_store;
   logic [stlb_pkg::PPN_W-1:0]      req_fill_ppn;
   logic                            req_fill_dirty;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_hit;
   logic [stlb_pkg::PPN_W-1:0]      rsp_ppn;
   logic                            rsp_dirty_update_needed;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [stlb_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [stlb_pkg::CSR_DATA_W-1:0] csr_wdata;

   int mismatches, pending, answers_checked, hits_checked;

   // idling policy, switched now and then by the stimulus
   bit gap_mode, stall_mode, quiet;
   int requests_sent;

   // small working set of page numbers so that lookups hit and sets overflow
   logic [stlb_pkg::VPN_W-1:0] vpn_pool [POOL_SIZE];

   // register settings walked by the random part: set_bits data, ways_used data
   // (includes zero ways, more ways than exist, and set_bits above the set count)
   logic [stlb_pkg::CSR_DATA_W-1:0] set_bits_plan  [NUM_SETTINGS] =
      '{4'd0, 4'd4, 4'd15, 4'd2, 4'd1, 4'd3, 4'd12, 4'd0, 4'd4, 4'd5};
   logic [stlb_pkg::CSR_DATA_W-1:0] ways_used_plan [NUM_SETTINGS] =
      '{4'd8, 4'd8, 4'd15, 4'd0, 4'd3, 4'd2, 4'd1, 4'd4, 4'd6, 4'd8};

   set_assoc_tlb_lru uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_op                  (req_op),
      .req_vpn                 (req_vpn),
      .req_store               (req_store),
      .req_fill_ppn            (req_fill_ppn),
      .req_fill_dirty          (req_fill_dirty),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_hit                 (rsp_hit),
      .rsp_ppn                 (rsp_ppn),
      .rsp_dirty_update_needed (rsp_dirty_update_needed),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   tlb_lru_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_op                  (req_op),
      .req_vpn                 (req_vpn),
      .req_store               (req_store),
      .req_fill_ppn            (req_fill_ppn),
      .req_fill_dirty          (req_fill_dirty),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_hit                 (rsp_hit),
      .rsp_ppn                 (rsp_ppn),
      .rsp_dirty_update_needed (rsp_dirty_update_needed),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .mismatches              (mismatches),
      .pending                 (pending),
      .answers_checked         (answers_checked),
      .hits_checked            (hits_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // page number near the working set: few sets, few tags, sometimes high bits set
   function automatic logic [stlb_pkg::VPN_W-1:0] nearby_vpn();
      logic [stlb_pkg::VPN_W-1:0] v;
      v = (20'($urandom_range(0, 9)) << 4) | 20'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0)
         v[19:16] = 4'hF;
      return v;
   endfunction

   // one request beat; inputs move on the falling edge, acceptance is seen at the
   // rising edge (values read right after the edge are the pre-edge ones)
   task automatic issue(
      input logic                            op,
      input logic [stlb_pkg::VPN_W-1:0]      vpn,
      input logic                            store,
      input logic [stlb_pkg::PPN_W-1:0]      fill_ppn,
      input logic                            fill_dirty
   );
      int gap;
      gap = (!quiet && gap_mode && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_vpn <= vpn;
      req_store <= store;
      req_fill_ppn <= fill_ppn;
      req_fill_dirty <= fill_dirty;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
   endtask

   // stop sending and let every outstanding answer come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(
      input logic [stlb_pkg::CSR_IDX_W-1:0]  idx,
      input logic [stlb_pkg::CSR_DATA_W-1:0] data
   );
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers only change with the pipeline empty
   task automatic configure(
      input logic [stlb_pkg::CSR_DATA_W-1:0] set_bits,
      input logic [stlb_pkg::CSR_DATA_W-1:0] ways_used
   );
      drain();
      write_reg(stlb_pkg::CSR_SET_BITS, set_bits);
      write_reg(stlb_pkg::CSR_WAYS_USED, ways_used);
   endtask

   // response side: random stall bursts while stall_mode is on
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && !quiet && stall_mode && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // hard stop, well past the slowest legal run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [stlb_pkg::VPN_W-1:0] v;
      int kind, sent, follow;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = stlb_pkg::OP_LOOKUP;
      req_vpn = '0;
      req_store = 1'b0;
      req_fill_ppn = '0;
      req_fill_dirty = 1'b0;
      csr_valid = 1'b0;
      csr_index = stlb_pkg::CSR_SET_BITS;
      csr_wdata = '0;
      gap_mode = 1'b0;
      stall_mode = 1'b0;
      quiet = 1'b0;
      requests_sent = 0;
      for (int i = 0; i < POOL_SIZE; i++)
         vpn_pool[i] = nearby_vpn();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // writes to undecoded indexes, with all data bits set, must change nothing
      write_reg(CSR_SPARE_LO, 4'hF);
      write_reg(CSR_SPARE_HI, 4'hF);

      // reset setting: one set, one way
      issue(stlb_pkg::OP_FILL,   20'h00000, 1'b0, 20'hFFFFF, 1'b0);
      issue(stlb_pkg::OP_LOOKUP, 20'h00000, 1'b0, 20'h00000, 1'b0);  // read hit
      issue(stlb_pkg::OP_LOOKUP, 20'h00000, 1'b1, 20'h00000, 1'b0);  // write hit, clean
      issue(stlb_pkg::OP_LOOKUP, 20'h00000, 1'b1, 20'hFFFFF, 1'b1);  // already dirty
      issue(stlb_pkg::OP_LOOKUP, 20'hFFFFF, 1'b0, 20'h00000, 1'b0);  // miss
      issue(stlb_pkg::OP_FILL,   20'hFFFFF, 1'b1, 20'h00000, 1'b1);  // evicts the only way
      issue(stlb_pkg::OP_LOOKUP, 20'hFFFFF, 1'b1, 20'h00000, 1'b0);  // dirty from fill
      issue(stlb_pkg::OP_LOOKUP, 20'h00000, 1'b0, 20'h00000, 1'b0);  // evicted, miss

      // two ways: fill into a free way, then refill of a tag already present
      configure(4'd0, 4'd2);
      issue(stlb_pkg::OP_FILL,   20'h00006, 1'b0, 20'h12345, 1'b0);
      issue(stlb_pkg::OP_FILL,   20'h00006, 1'b0, 20'hABCDE, 1'b0);
      issue(stlb_pkg::OP_LOOKUP, 20'h00006, 1'b0, 20'h00000, 1'b0);

      // shrink to one way: way 1 is hidden, so the same tag lands in way 0 too
      configure(4'd0, 4'd1);
      issue(stlb_pkg::OP_FILL,   20'h00006, 1'b0, 20'h55555, 1'b0);

      // back to two ways: duplicate tags, lowest way must answer; then evict by age
      configure(4'd0, 4'd2);
      issue(stlb_pkg::OP_LOOKUP, 20'h00006, 1'b1, 20'h00000, 1'b0);
      issue(stlb_pkg::OP_FILL,   20'h00007, 1'b0, 20'h0F0F0, 1'b1);
      issue(stlb_pkg::OP_LOOKUP, 20'h00007, 1'b0, 20'h00000, 1'b0);
      issue(stlb_pkg::OP_LOOKUP, 20'h00006, 1'b0, 20'h00000, 1'b0);

      // zero ways acts as one; set_bits above the set count is clamped
      configure(4'd7, 4'd0);
      issue(stlb_pkg::OP_FILL,   20'hFFFFF, 1'b0, 20'h00001, 1'b0);
      issue(stlb_pkg::OP_LOOKUP, 20'hFFFFF, 1'b0, 20'h00000, 1'b0);
      issue(stlb_pkg::OP_LOOKUP, 20'h0000F, 1'b1, 20'h00000, 1'b0);  // same set, other tag
      issue(stlb_pkg::OP_FILL,   20'h0000F, 1'b0, 20'hFFFFF, 1'b1);
      issue(stlb_pkg::OP_LOOKUP, 20'hFFFFF, 1'b0, 20'h00000, 1'b0);  // evicted

      // random part: entries survive each register change, so ages drift
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         configure(set_bits_plan[s], ways_used_plan[s]);
         sent = 0;
         while (sent < ITEMS_PER_SETTING) begin
            if (sent % 40 == 0) begin
               gap_mode = ($urandom_range(0, 2) != 0);
               stall_mode = ($urandom_range(0, 2) != 0);
            end
            // the tail of the run goes at full rate on both sides
            if (s == NUM_SETTINGS - 1 && sent >= ITEMS_PER_SETTING - 60)
               quiet = 1'b1;
            if ($urandom_range(0, 4) == 0)
               v = nearby_vpn();
            else
               v = vpn_pool[$urandom_range(0, POOL_SIZE - 1)];
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               // plain lookup in the working set
               issue(stlb_pkg::OP_LOOKUP, v, 1'($urandom_range(0, 1)), 20'($urandom),
                     1'($urandom_range(0, 1)));
               sent++;
            end else if (kind < 85) begin
               // fill followed by lookups of the same page, some of them writes
               issue(stlb_pkg::OP_FILL, v, 1'($urandom_range(0, 1)), 20'($urandom),
                     1'($urandom_range(0, 1)));
               follow = $urandom_range(1, 3);
               repeat (follow)
                  issue(stlb_pkg::OP_LOOKUP, v, 1'($urandom_range(0, 1)), 20'($urandom),
                        1'($urandom_range(0, 1)));
               sent += 1 + follow;
            end else begin
               // noise anywhere in the page space
               issue(1'($urandom_range(0, 1)), 20'($urandom), 1'($urandom_range(0, 1)),
                     20'($urandom), 1'($urandom_range(0, 1)));
               sent++;
            end
            if ($urandom_range(0, 19) == 0)
               vpn_pool[$urandom_range(0, POOL_SIZE - 1)] = nearby_vpn();
         end
      end

      drain();
      repeat (10) @(negedge clock);

      $display("%0d requests sent under %0d register settings", requests_sent,
               NUM_SETTINGS + 5);
      $display("%0d responses checked, %0d of them hits", answers_checked, hits_checked);
      if (mismatches == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
